[hw/rtl/grouped_window_average_alarm_macros.svh]
// ============================================================================
// grouped_window_average_alarm assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ============================================================================
`ifndef GROUPED_WINDOW_AVERAGE_ALARM_MACROS_SVH
`define GROUPED_WINDOW_AVERAGE_ALARM_MACROS_SVH

`ifndef SYNTHESIS

`define GWAA_ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gwaa assertion failed");

`define GWAA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("gwaa forbidden condition seen");

`else

`define GWAA_ASSERT_PROP(lbl, clk, rst_n, prop)

`define GWAA_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[hw/rtl/gwaa_pkg.sv]
// ============================================================================
// gwaa_pkg
// shared widths, register indexes and the stage-to-stage operation type
// ============================================================================
package gwaa_pkg;

    localparam int DISK_W  = 16;
    localparam int TIME_W  = 32;
    localparam int LABEL_W = 2;
    localparam int PRED_W  = 16;
    localparam int TALLY_W = 16;
    localparam int WLEN_W  = 7;
    localparam int THR_W   = 16;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam logic [LABEL_W-1:0] LABEL_HEALTHY = 2'b00;
    localparam logic [LABEL_W-1:0] LABEL_FAILING = 2'b01;

    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    typedef enum logic {
        REG_WINDOW_LEN = 1'b0,
        REG_THRESHOLD  = 1'b1
    } gwaa_reg_t;

    // one accepted transaction as seen by the evaluation stage
    typedef struct packed {
        logic               close_prev;
        logic               start;
        logic               has_sample;
        logic               closes;
        logic               eval;
        logic               zero_base;
        logic               close_counted;
        logic [DISK_W-1:0]  disk;
        logic [LABEL_W-1:0] label;
        logic [TIME_W-1:0]  stamp;
    } gwaa_op_t;

    function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] v);
        return (v == TALLY_MAX) ? v : v + TALLY_W'(1);
    endfunction

endpackage

[hw/rtl/gwaa_ring_mem.sv]
// ============================================================================
// gwaa_ring_mem
// prefix-sum ring, one write and one registered read port, read-first
// ============================================================================
module gwaa_ring_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 22
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/gwaa_track.sv]
// ============================================================================
// gwaa_track
// group tracking, ring pointer and fill count, prefix sum and ring access
// ============================================================================
module gwaa_track import gwaa_pkg::*; #(
    parameter int MAX_WINDOW = 64,
    parameter int PTR_W      = 6,
    parameter int CNT_W      = 7,
    parameter int SUM_W      = 22
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic               stall,
    input  logic [DISK_W-1:0]  disk_id,
    input  logic [TIME_W-1:0]  sample_time,
    input  logic [LABEL_W-1:0] label_class,
    input  logic [PRED_W-1:0]  prediction,
    input  logic               end_of_data,
    input  logic [CNT_W-1:0]   eff_w,
    output logic               mem_wr_en,
    output logic [PTR_W-1:0]   mem_wr_addr,
    output logic [SUM_W-1:0]   mem_wr_data,
    output logic               mem_rd_en,
    output logic [PTR_W-1:0]   mem_rd_addr,
    output logic               op_valid,
    output gwaa_op_t           op,
    output logic [SUM_W-1:0]   prefix
);

    logic              active_reg;
    logic [DISK_W-1:0] disk_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  pre_reg;
    logic              op_valid_reg;
    gwaa_op_t          op_reg;
    logic [SUM_W-1:0]  pn_reg;

    logic              close_prev;
    logic              fresh;
    logic              keep;
    logic [PTR_W-1:0]  base_ptr;
    logic [CNT_W-1:0]  base_cnt;
    logic [SUM_W-1:0]  base_pre;
    logic signed [SUM_W-1:0] pred_ext;
    logic [SUM_W-1:0]  pn;
    logic [CNT_W-1:0]  cnt_next;
    logic [PTR_W-1:0]  ptr_next;
    logic [CNT_W:0]    back;
    logic [CNT_W:0]    back_wrap;
    gwaa_op_t          op_next;

    always_comb begin
        close_prev = active_reg && (disk_id != disk_reg);
        fresh      = !active_reg || close_prev;
        keep       = !(close_prev && end_of_data);
        base_ptr   = fresh ? '0 : ptr_reg;
        base_cnt   = fresh ? '0 : cnt_reg;
        base_pre   = fresh ? '0 : pre_reg;
        pred_ext   = SUM_W'($signed(prediction));
        pn         = base_pre + SUM_W'(pred_ext);
        cnt_next   = (base_cnt == CNT_W'(MAX_WINDOW + 1)) ? base_cnt : base_cnt + CNT_W'(1);
        ptr_next   = (base_ptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : base_ptr + PTR_W'(1);
        back       = (CNT_W+1)'(base_ptr) + (CNT_W+1)'(MAX_WINDOW) - (CNT_W+1)'(eff_w);
        back_wrap  = (back >= (CNT_W+1)'(MAX_WINDOW)) ? back - (CNT_W+1)'(MAX_WINDOW) : back;

        op_next.close_prev    = close_prev;
        op_next.start         = fresh && keep;
        op_next.has_sample    = keep;
        op_next.closes        = keep && end_of_data;
        op_next.eval          = keep && (cnt_next >= eff_w);
        op_next.zero_base     = (cnt_next == eff_w);
        op_next.close_counted = close_prev ? (cnt_reg >= eff_w) : (cnt_next >= eff_w);
        op_next.disk          = disk_id;
        op_next.label         = label_class;
        op_next.stamp         = sample_time;
    end

    assign mem_wr_en   = accept && keep;
    assign mem_wr_addr = base_ptr;
    assign mem_wr_data = pn;
    assign mem_rd_en   = accept && keep;
    assign mem_rd_addr = PTR_W'(back_wrap);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            op_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                active_reg <= keep && !end_of_data;
            end
            if (!stall) begin
                op_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && keep) begin
            disk_reg <= disk_id;
            ptr_reg  <= ptr_next;
            cnt_reg  <= cnt_next;
            pre_reg  <= pn;
        end
        if (!stall) begin
            op_reg <= op_next;
            pn_reg <= pn;
        end
    end

    assign op_valid = op_valid_reg;
    assign op       = op_reg;
    assign prefix   = pn_reg;

endmodule

[hw/rtl/gwaa_judge.sv]
// ============================================================================
// gwaa_judge
// window compare, alarm and decision time, tallies and the record register
// ============================================================================
module gwaa_judge import gwaa_pkg::*; #(
    parameter int SUM_W = 22
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               op_valid,
    input  gwaa_op_t           op,
    input  logic [SUM_W-1:0]   prefix,
    input  logic [SUM_W-1:0]   base,
    input  logic [SUM_W-1:0]   thr_w,
    input  logic               m_ready,
    output logic               stall,
    output logic               m_valid,
    output logic [DISK_W-1:0]  m_closed_disk,
    output logic               m_counted,
    output logic               m_alarmed,
    output logic [LABEL_W-1:0] m_disk_label,
    output logic [TIME_W-1:0]  m_decision_time,
    output logic [TALLY_W-1:0] m_true_pos,
    output logic [TALLY_W-1:0] m_false_pos,
    output logic [TALLY_W-1:0] m_total_pos,
    output logic [TALLY_W-1:0] m_total_neg
);

    logic               alarm_reg;
    logic [DISK_W-1:0]  disk_reg;
    logic [LABEL_W-1:0] label_reg;
    logic [TIME_W-1:0]  held_reg;
    logic [TALLY_W-1:0] tp_reg;
    logic [TALLY_W-1:0] fp_reg;
    logic [TALLY_W-1:0] pos_reg;
    logic [TALLY_W-1:0] neg_reg;
    logic               m_valid_reg;
    logic [DISK_W-1:0]  disk_out_reg;
    logic               counted_out_reg;
    logic               alarm_out_reg;
    logic [LABEL_W-1:0] label_out_reg;
    logic [TIME_W-1:0]  time_out_reg;

    logic               emit;
    logic               proceed;
    logic [DISK_W-1:0]  disk_c;
    logic [LABEL_W-1:0] label_c;
    logic               alarm_c;
    logic [TIME_W-1:0]  held_c;
    logic [SUM_W-1:0]   win_sum;
    logic               hit;
    logic               eval_now;
    logic               alarm_n;
    logic [TIME_W-1:0]  held_n;
    logic [DISK_W-1:0]  rec_disk;
    logic [LABEL_W-1:0] rec_label;
    logic               rec_alarm;
    logic [TIME_W-1:0]  rec_held;
    logic               rec_counted;
    logic [TALLY_W-1:0] tp_next;
    logic [TALLY_W-1:0] fp_next;
    logic [TALLY_W-1:0] pos_next;
    logic [TALLY_W-1:0] neg_next;

    assign emit    = op.close_prev || op.closes;
    assign stall   = op_valid && emit && m_valid_reg && !m_ready;
    assign proceed = op_valid && !stall;

    always_comb begin
        disk_c   = op.start ? op.disk  : disk_reg;
        label_c  = op.start ? op.label : label_reg;
        alarm_c  = op.start ? 1'b0     : alarm_reg;
        held_c   = op.start ? '0       : held_reg;
        win_sum  = prefix - (op.zero_base ? '0 : base);
        hit      = $signed(win_sum) > $signed(thr_w);
        eval_now = op.has_sample && op.eval && !alarm_c;
        alarm_n  = alarm_c || (eval_now && hit);
        held_n   = eval_now ? op.stamp : held_c;

        // record of the group left behind, or of the group the end flag closes
        if (op.close_prev) begin
            rec_disk    = disk_reg;
            rec_label   = label_reg;
            rec_alarm   = alarm_reg;
            rec_held    = held_reg;
            rec_counted = op.close_counted || alarm_reg;
        end else begin
            rec_disk    = disk_c;
            rec_label   = label_c;
            rec_alarm   = alarm_n;
            rec_held    = held_n;
            rec_counted = op.close_counted || alarm_n;
        end

        tp_next  = tp_reg;
        fp_next  = fp_reg;
        pos_next = pos_reg;
        neg_next = neg_reg;
        if (rec_counted && (rec_label == LABEL_HEALTHY)) begin
            neg_next = sat_inc(neg_reg);
            if (rec_alarm) begin
                fp_next = sat_inc(fp_reg);
            end
        end else if (rec_counted && (rec_label == LABEL_FAILING)) begin
            pos_next = sat_inc(pos_reg);
            if (rec_alarm) begin
                tp_next = sat_inc(tp_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_reg   <= 1'b0;
            tp_reg      <= '0;
            fp_reg      <= '0;
            pos_reg     <= '0;
            neg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (proceed && op.has_sample) begin
                alarm_reg <= alarm_n;
            end
            if (proceed && emit) begin
                tp_reg      <= tp_next;
                fp_reg      <= fp_next;
                pos_reg     <= pos_next;
                neg_reg     <= neg_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed && op.has_sample) begin
            disk_reg  <= disk_c;
            label_reg <= label_c;
            held_reg  <= held_n;
        end
        if (proceed && emit) begin
            disk_out_reg    <= rec_disk;
            counted_out_reg <= rec_counted;
            alarm_out_reg   <= rec_counted && rec_alarm;
            label_out_reg   <= rec_label;
            time_out_reg    <= rec_counted ? rec_held : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_closed_disk   = disk_out_reg;
    assign m_counted       = counted_out_reg;
    assign m_alarmed       = alarm_out_reg;
    assign m_disk_label    = label_out_reg;
    assign m_decision_time = time_out_reg;
    assign m_true_pos      = tp_reg;
    assign m_false_pos     = fp_reg;
    assign m_total_pos     = pos_reg;
    assign m_total_neg     = neg_reg;

endmodule

[hw/rtl/grouped_window_average_alarm.sv]
// ============================================================================
// grouped_window_average_alarm
// per-disk moving-window mean threshold alarm with saturating outcome tallies
// ============================================================================
// Takes one sample per clock cycle while s_ready is high. Each sample writes
// a running prefix sum into a MAX_WINDOW-entry ring memory and, in the same
// cycle, reads the prefix from window_len samples back; the next cycle
// subtracts the two and compares against alarm_threshold times the clamped
// window_len, so the window mean costs one memory write and one memory read
// per sample whatever the window length. A closed group's record passes the
// gwaa_track op register, then the gwaa_judge record register; a stall can
// hold it in the first. Input ready drops only while a record is about to
// be produced and the previous record still waits on m_ready. Configuration
// takes effect for samples accepted from the cycle after the write.
// ============================================================================
`include "grouped_window_average_alarm_macros.svh"

module grouped_window_average_alarm import gwaa_pkg::*; #(
    parameter int MAX_WINDOW = 64
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [DISK_W-1:0]  s_disk_id,
    input  logic [TIME_W-1:0]  s_sample_time,
    input  logic [LABEL_W-1:0] s_label_class,
    input  logic [PRED_W-1:0]  s_prediction,
    input  logic               s_end_of_data,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [DISK_W-1:0]  m_closed_disk,
    output logic               m_counted,
    output logic               m_alarmed,
    output logic [LABEL_W-1:0] m_disk_label,
    output logic [TIME_W-1:0]  m_decision_time,
    output logic [TALLY_W-1:0] m_true_pos,
    output logic [TALLY_W-1:0] m_false_pos,
    output logic [TALLY_W-1:0] m_total_pos,
    output logic [TALLY_W-1:0] m_total_neg
);

    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 2);
    localparam int SUM_W = PRED_W + $clog2(MAX_WINDOW);
    localparam int CMP_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

    logic [WLEN_W-1:0] window_len_reg;
    logic [THR_W-1:0]  alarm_threshold_reg;
    logic [SUM_W-1:0]  thr_w_reg;
    logic [SUM_W-1:0]  thr_w_next;

    logic              cfg_wr;
    gwaa_reg_t         reg_sel;
    logic [CMP_W-1:0]  wl_ext;
    logic [CNT_W-1:0]  eff_w;
    logic signed [THR_W+CNT_W:0] thr_prod;

    logic              accept;
    logic              stall;
    logic              mem_wr_en;
    logic [PTR_W-1:0]  mem_wr_addr;
    logic [SUM_W-1:0]  mem_wr_data;
    logic              mem_rd_en;
    logic [PTR_W-1:0]  mem_rd_addr;
    logic [SUM_W-1:0]  mem_rd_data;
    logic              op_valid;
    gwaa_op_t          op;
    logic [SUM_W-1:0]  prefix;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = gwaa_reg_t'(paddr[2]);

    always_comb begin
        unique case (reg_sel)
            REG_WINDOW_LEN: prdata = APB_DW'(window_len_reg);
            REG_THRESHOLD:  prdata = APB_DW'(alarm_threshold_reg);
            default:        prdata = '0;
        endcase
    end

    // window length clamped to 1..MAX_WINDOW
    always_comb begin
        wl_ext = CMP_W'(window_len_reg);
        if (wl_ext == '0) begin
            eff_w = CNT_W'(1);
        end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
            eff_w = CNT_W'(MAX_WINDOW);
        end else begin
            eff_w = CNT_W'(wl_ext);
        end
    end

    assign thr_prod   = $signed(alarm_threshold_reg) * $signed({1'b0, eff_w});
    assign thr_w_next = SUM_W'(thr_prod);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg      <= WLEN_W'(1);
            alarm_threshold_reg <= '0;
            thr_w_reg           <= '0;
        end else begin
            thr_w_reg <= thr_w_next;
            if (cfg_wr && (reg_sel == REG_WINDOW_LEN)) begin
                window_len_reg <= pwdata[WLEN_W-1:0];
            end
            if (cfg_wr && (reg_sel == REG_THRESHOLD)) begin
                alarm_threshold_reg <= pwdata[THR_W-1:0];
            end
        end
    end

    assign s_ready = !stall;
    assign accept  = s_valid && s_ready;

    gwaa_track #(
        .MAX_WINDOW (MAX_WINDOW),
        .PTR_W      (PTR_W),
        .CNT_W      (CNT_W),
        .SUM_W      (SUM_W)
    ) u_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .stall       (stall),
        .disk_id     (s_disk_id),
        .sample_time (s_sample_time),
        .label_class (s_label_class),
        .prediction  (s_prediction),
        .end_of_data (s_end_of_data),
        .eff_w       (eff_w),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .op_valid    (op_valid),
        .op          (op),
        .prefix      (prefix)
    );

    gwaa_ring_mem #(
        .DEPTH  (MAX_WINDOW),
        .ADDR_W (PTR_W),
        .DATA_W (SUM_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    gwaa_judge #(
        .SUM_W (SUM_W)
    ) u_judge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .op_valid        (op_valid),
        .op              (op),
        .prefix          (prefix),
        .base            (mem_rd_data),
        .thr_w           (thr_w_reg),
        .m_ready         (m_ready),
        .stall           (stall),
        .m_valid         (m_valid),
        .m_closed_disk   (m_closed_disk),
        .m_counted       (m_counted),
        .m_alarmed       (m_alarmed),
        .m_disk_label    (m_disk_label),
        .m_decision_time (m_decision_time),
        .m_true_pos      (m_true_pos),
        .m_false_pos     (m_false_pos),
        .m_total_pos     (m_total_pos),
        .m_total_neg     (m_total_neg)
    );

    `GWAA_ASSERT_PROP(a_ready_low_only_when_blocked, aclk, aresetn, !s_ready |-> (m_valid && !m_ready))
    `GWAA_ASSERT_NEVER(a_alarm_without_count, aclk, aresetn, m_valid && m_alarmed && !m_counted)
    `GWAA_ASSERT_NEVER(a_uncounted_time_nonzero, aclk, aresetn, m_valid && !m_counted && (m_decision_time != '0))
    `GWAA_ASSERT_NEVER(a_true_pos_exceeds_total, aclk, aresetn, m_true_pos > m_total_pos)

endmodule
